// ===== src/gas_temp_alarm_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAS_TEMP_ALARM_CONTROLLER_DEFINES_SVH
`define GAS_TEMP_ALARM_CONTROLLER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GTAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GTAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gtac_pkg.sv =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller package
// Shared widths, reset values, register map and types.
// ----------------------------------------------------------------------------
package gtac_pkg;

    localparam int DEF_WINDOW_DEPTH = 100;
    localparam int DEF_SAMPLE_BITS  = 12;
    localparam int DEF_KEY_COUNT    = 4;

    localparam int CODE_W  = 4;
    localparam int LIMIT_W = 20;
    localparam int BLINK_W = 10;
    localparam int ATT_W   = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [CODE_W-1:0]  RST_UNLOCK_CODE  = 4'd3;
    localparam logic [LIMIT_W-1:0] RST_TEMP_LIMIT   = 20'd62045;
    localparam logic [BLINK_W-1:0] RST_BLINK_GAS    = 10'd100;
    localparam logic [BLINK_W-1:0] RST_BLINK_TEMP   = 10'd50;
    localparam logic [BLINK_W-1:0] RST_BLINK_BOTH   = 10'd10;
    localparam logic [ATT_W-1:0]   RST_MAX_ATTEMPTS = 4'd5;

    localparam logic [BLINK_W-1:0] COUNT_MAX = '1;

    localparam int LED_ALARM   = 0;
    localparam int LED_BLOCKED = 1;
    localparam int LED_WRONG   = 2;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_UNLOCK_CODE  = 3'd0;
    localparam t_reg_idx REG_TEMP_LIMIT   = 3'd1;
    localparam t_reg_idx REG_BLINK_GAS    = 3'd2;
    localparam t_reg_idx REG_BLINK_TEMP   = 3'd3;
    localparam t_reg_idx REG_BLINK_BOTH   = 3'd4;
    localparam t_reg_idx REG_MAX_ATTEMPTS = 3'd5;

    typedef struct packed {
        logic [CODE_W-1:0]  unlock_code;
        logic [LIMIT_W-1:0] temp_limit_sum;
        logic [BLINK_W-1:0] blink_gas_ticks;
        logic [BLINK_W-1:0] blink_temp_ticks;
        logic [BLINK_W-1:0] blink_both_ticks;
        logic [ATT_W-1:0]   max_wrong_attempts;
    } t_cfg;

    typedef struct packed {
        logic alarm_led;
        logic blocked_led;
        logic wrong_code_led;
        logic alarm_active;
        logic over_temp;
    } t_result;

endpackage

// ===== src/gtac_if.sv =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller channels
// Tick input channel and result output channel with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gtac_in_if #(
    parameter int SAMPLE_BITS = gtac_pkg::DEF_SAMPLE_BITS,
    parameter int KEY_COUNT   = gtac_pkg::DEF_KEY_COUNT
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] temp_sample;
    logic                   gas_sense_n;
    logic                   test_button;
    logic [KEY_COUNT-1:0]   code_keys;
    logic                   enter_button;

    modport source (
        output valid, temp_sample, gas_sense_n, test_button, code_keys, enter_button,
        input  ready
    );
    modport sink (
        input  valid, temp_sample, gas_sense_n, test_button, code_keys, enter_button,
        output ready
    );
endinterface

interface gtac_out_if;
    logic valid;
    logic ready;
    logic alarm_led;
    logic blocked_led;
    logic wrong_code_led;
    logic alarm_active;
    logic over_temp;

    modport source (
        output valid, alarm_led, blocked_led, wrong_code_led, alarm_active, over_temp,
        input  ready
    );
    modport sink (
        input  valid, alarm_led, blocked_led, wrong_code_led, alarm_active, over_temp,
        output ready
    );
endinterface

// ===== src/gtac_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// APB write and read access to the six alarm configuration registers.
// ----------------------------------------------------------------------------
module gtac_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gtac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gtac_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output gtac_pkg::t_cfg                  o_cfg
);
    import gtac_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_code        <= RST_UNLOCK_CODE;
            r_cfg.temp_limit_sum     <= RST_TEMP_LIMIT;
            r_cfg.blink_gas_ticks    <= RST_BLINK_GAS;
            r_cfg.blink_temp_ticks   <= RST_BLINK_TEMP;
            r_cfg.blink_both_ticks   <= RST_BLINK_BOTH;
            r_cfg.max_wrong_attempts <= RST_MAX_ATTEMPTS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_UNLOCK_CODE:  r_cfg.unlock_code        <= pwdata[CODE_W-1:0];
                REG_TEMP_LIMIT:   r_cfg.temp_limit_sum     <= pwdata[LIMIT_W-1:0];
                REG_BLINK_GAS:    r_cfg.blink_gas_ticks    <= pwdata[BLINK_W-1:0];
                REG_BLINK_TEMP:   r_cfg.blink_temp_ticks   <= pwdata[BLINK_W-1:0];
                REG_BLINK_BOTH:   r_cfg.blink_both_ticks   <= pwdata[BLINK_W-1:0];
                REG_MAX_ATTEMPTS: r_cfg.max_wrong_attempts <= pwdata[ATT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_UNLOCK_CODE:  prdata = APB_DATA_W'(r_cfg.unlock_code);
            REG_TEMP_LIMIT:   prdata = APB_DATA_W'(r_cfg.temp_limit_sum);
            REG_BLINK_GAS:    prdata = APB_DATA_W'(r_cfg.blink_gas_ticks);
            REG_BLINK_TEMP:   prdata = APB_DATA_W'(r_cfg.blink_temp_ticks);
            REG_BLINK_BOTH:   prdata = APB_DATA_W'(r_cfg.blink_both_ticks);
            REG_MAX_ATTEMPTS: prdata = APB_DATA_W'(r_cfg.max_wrong_attempts);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== src/gtac_window.sv =====
// ----------------------------------------------------------------------------
// Temperature window
// Sample memory with running sum and over-temperature compare.
// ----------------------------------------------------------------------------
module gtac_window #(
    parameter int WINDOW_DEPTH = gtac_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = gtac_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic [gtac_pkg::LIMIT_W-1:0] i_limit,
    output logic                         o_over
);
    import gtac_pkg::*;

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = SAMPLE_BITS + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0);
    localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_DEPTH - 1);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_DEPTH];
    logic [PTR_W-1:0]       r_ptr;
    logic [PTR_W-1:0]       n_ptr;
    logic                   r_full;
    logic                   n_full;
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;

    // The entry at the next pointer holds a written sample only once the window has wrapped.
    assign n_ptr  = (r_ptr == LAST_PTR) ? '0 : r_ptr + 1'b1;
    assign n_full = r_full | (r_ptr == LAST_PTR);
    assign n_sum  = r_sum - SUM_W'(r_old) + SUM_W'(i_sample);
    assign o_over = CMP_W'(n_sum) > CMP_W'(i_limit);

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mem[r_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
            r_old  <= '0;
        end else if (i_step) begin
            r_ptr  <= n_ptr;
            r_full <= n_full;
            r_sum  <= n_sum;
            if (!n_full) begin
                r_old <= '0;
            end else if (n_ptr == r_ptr) begin
                r_old <= i_sample;
            end else begin
                r_old <= r_mem[n_ptr];
            end
        end
    end

endmodule

// ===== src/gtac_alarm.sv =====
// ----------------------------------------------------------------------------
// Alarm and keypad logic
// Cause latches, blink counter, LED bits and wrong-attempt counter.
// ----------------------------------------------------------------------------
module gtac_alarm #(
    parameter int KEY_COUNT = gtac_pkg::DEF_KEY_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_gas_sense_n,
    input  logic                 i_test_button,
    input  logic [KEY_COUNT-1:0] i_code_keys,
    input  logic                 i_enter_button,
    input  logic                 i_over,
    input  gtac_pkg::t_cfg       i_cfg,
    output gtac_pkg::t_result    o_result
);
    import gtac_pkg::*;

    localparam int CMPK_W = (KEY_COUNT > CODE_W) ? KEY_COUNT : CODE_W;
    localparam logic [KEY_COUNT-1:0] ALL_KEYS = '1;

    logic               r_alarm;
    logic               n_alarm;
    logic               r_gas;
    logic               n_gas;
    logic               r_heat;
    logic               n_heat;
    logic [BLINK_W-1:0] r_blink;
    logic [BLINK_W-1:0] n_blink;
    logic [2:0]         r_leds;
    logic [2:0]         n_leds;
    logic [ATT_W-1:0]   r_wrong;
    logic [ATT_W-1:0]   n_wrong;
    logic [BLINK_W-1:0] half;
    logic [KEY_COUNT-1:0] code_k;
    logic               gas;

    assign code_k = KEY_COUNT'(CMPK_W'(i_cfg.unlock_code));

    always_comb begin
        gas     = !i_gas_sense_n;
        n_alarm = r_alarm | gas | i_over | i_test_button;
        n_gas   = r_gas | gas | i_test_button;
        n_heat  = r_heat | i_over | i_test_button;
        n_blink = r_blink;
        n_leds  = r_leds;
        n_wrong = r_wrong;
        half    = '0;

        if (n_alarm) begin
            if (r_blink != COUNT_MAX) begin
                n_blink = r_blink + 1'b1;
            end
            if (n_gas && n_heat) begin
                half = i_cfg.blink_both_ticks;
            end else if (n_gas) begin
                half = i_cfg.blink_gas_ticks;
            end else begin
                half = i_cfg.blink_temp_ticks;
            end
            if ((n_gas || n_heat) && (n_blink >= half)) begin
                n_blink            = '0;
                n_leds[LED_ALARM]  = ~r_leds[LED_ALARM];
            end
        end else begin
            n_leds = '0;
            n_gas  = 1'b0;
            n_heat = 1'b0;
        end

        if (r_wrong < i_cfg.max_wrong_attempts) begin
            if ((i_code_keys == ALL_KEYS) && !i_enter_button) begin
                n_leds[LED_WRONG] = 1'b0;
            end
            if (i_enter_button && !n_leds[LED_WRONG] && n_alarm) begin
                if (i_code_keys == code_k) begin
                    n_alarm = 1'b0;
                    n_wrong = '0;
                end else begin
                    n_leds[LED_WRONG] = 1'b1;
                    n_wrong           = r_wrong + 1'b1;
                end
            end
        end else begin
            n_leds[LED_BLOCKED] = 1'b1;
        end

        o_result.alarm_led      = n_leds[LED_ALARM];
        o_result.blocked_led    = n_leds[LED_BLOCKED];
        o_result.wrong_code_led = n_leds[LED_WRONG];
        o_result.alarm_active   = n_alarm;
        o_result.over_temp      = i_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm <= 1'b0;
            r_gas   <= 1'b0;
            r_heat  <= 1'b0;
            r_blink <= '0;
            r_leds  <= '0;
            r_wrong <= '0;
        end else if (i_step) begin
            r_alarm <= n_alarm;
            r_gas   <= n_gas;
            r_heat  <= n_heat;
            r_blink <= n_blink;
            r_leds  <= n_leds;
            r_wrong <= n_wrong;
        end
    end

endmodule

// ===== src/gas_temp_alarm_controller.sv =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller
// Processes one 10 ms tick per input beat and returns one status beat per tick.
// ----------------------------------------------------------------------------
// The input channel carries one tick beat: temperature sample, gas line, test
// button, code keys and enter key. The output channel returns one beat per tick
// with the LED states, the latched alarm and the over-temperature flag.
// Configuration registers must be written over the APB port only while no tick is
// in flight, which the block itself does not enforce; pready is always high and
// reads return the register contents. A tick beat is registered at the input,
// evaluated once the output register can advance and registered at the output.
// One beat is taken every cycle while the receiver keeps ready high; the window
// memory is read and written once per tick and sets that rate.
// Reset clears the window, the running sum, all latches, counters and LEDs,
// and loads the register reset values. When the receiver stalls, the output
// beat holds and one more input beat is still taken into the input register
// before ready drops.
// ----------------------------------------------------------------------------
module gas_temp_alarm_controller #(
    parameter int WINDOW_DEPTH = gtac_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = gtac_pkg::DEF_SAMPLE_BITS,
    parameter int KEY_COUNT    = gtac_pkg::DEF_KEY_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gtac_in_if.sink                         i_in,
    gtac_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gtac_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gtac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gtac_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import gtac_pkg::*;

    t_cfg                   cfg;
    t_result                result;
    t_result                r_out;
    logic                   r_out_valid;
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_in_gas_n;
    logic                   r_in_test;
    logic [KEY_COUNT-1:0]   r_in_keys;
    logic                   r_in_enter;
    logic                   advance;
    logic                   step;
    logic                   over;

    assign advance    = !r_out_valid | o_out.ready;
    assign step       = r_in_valid & advance;
    assign i_in.ready = !r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_sample <= i_in.temp_sample;
            r_in_gas_n  <= i_in.gas_sense_n;
            r_in_test   <= i_in.test_button;
            r_in_keys   <= i_in.code_keys;
            r_in_enter  <= i_in.enter_button;
        end
        if (step) begin
            r_out <= result;
        end
    end

    gtac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gtac_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_in_sample),
        .i_limit  (cfg.temp_limit_sum),
        .o_over   (over)
    );

    gtac_alarm #(
        .KEY_COUNT (KEY_COUNT)
    ) u_alarm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_gas_sense_n  (r_in_gas_n),
        .i_test_button  (r_in_test),
        .i_code_keys    (r_in_keys),
        .i_enter_button (r_in_enter),
        .i_over         (over),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.alarm_led      = r_out.alarm_led;
    assign o_out.blocked_led    = r_out.blocked_led;
    assign o_out.wrong_code_led = r_out.wrong_code_led;
    assign o_out.alarm_active   = r_out.alarm_active;
    assign o_out.over_temp      = r_out.over_temp;

endmodule

// ===== src/gtac_checker.sv =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller port checker
// Observes the top-level ports and checks buffering, reset behavior and APB pready.
// ----------------------------------------------------------------------------
`include "gas_temp_alarm_controller_defines.svh"

module gtac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_bits,
    input logic       i_pready
);

    `GTAC_ASSERT_SAME(a_no_beat_after_reset, $rose(i_rst_n), !i_out_valid, "Output beat right after reset")

    `GTAC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bits), "Stalled output beat changed")

    `GTAC_ASSERT_NEXT(a_buffer_full, i_out_valid && !i_out_ready && i_in_valid && i_in_ready, i_out_ready || !i_in_ready, "Beat taken with both stages full")

    `GTAC_ASSERT_SAME(a_pready_high, 1'b1, i_pready, "APB pready dropped")

endmodule

bind gas_temp_alarm_controller gtac_checker u_gtac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bits  ({o_out.alarm_led, o_out.blocked_led, o_out.wrong_code_led,
                   o_out.alarm_active, o_out.over_temp}),
    .i_pready    (pready)
);

// ===== verif/gas_temp_alarm_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller testbench
// Drives tick beats with random gaps and random receiver stalls, but for one calm
// phase, predicts status beats from a cycle-free model of the window, alarm latches,
// blink and keypad or takes them from the table, and compares each returned beat
// field by field. A short table of directed ticks comes first, then phases of random
// ticks under different register settings, the extremes among them.
// ----------------------------------------------------------------------------
module gas_temp_alarm_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtac_pkg::*;

    localparam int WINDOW_DEPTH    = DEF_WINDOW_DEPTH;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int STALL_LIMIT     = 2000;
    localparam int DIR_ROWS        = 25;

    typedef struct packed {
        logic [DEF_SAMPLE_BITS-1:0] temp_sample;
        logic                       gas_sense_n;
        logic                       test_button;
        logic [DEF_KEY_COUNT-1:0]   code_keys;
        logic                       enter_button;
    } t_tick;

    typedef struct packed {
        logic    known;
        t_result status;
    } t_known;

    typedef struct packed {
        t_tick   tick;
        logic    known;
        t_result status;
    } t_dir_row;

    // Status bits are alarm_led, blocked_led, wrong_code_led, alarm_active, over_temp.
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b0}, 1'b1, 5'b00000},
        '{'{12'd4095, 1'b1, 1'b0, 4'h0, 1'b0}, 1'b1, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h3, 1'b1}, 1'b1, 5'b00000},
        '{'{12'd1,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b1, 5'b00000},
        '{'{12'd2048, 1'b0, 1'b0, 4'h0, 1'b0}, 1'b1, 5'b00010},
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b1}, 1'b1, 5'b00110},
        '{'{12'd0,    1'b1, 1'b0, 4'h3, 1'b1}, 1'b1, 5'b00110},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b1, 5'b00010},
        '{'{12'd0,    1'b1, 1'b0, 4'h3, 1'b1}, 1'b1, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b0}, 1'b1, 5'b00000},
        '{'{12'd100,  1'b1, 1'b1, 4'h0, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h3, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b0}, 1'b1, 5'b00000},
        '{'{12'd0,    1'b0, 1'b0, 4'h0, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h5, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hA, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hC, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h0, 1'b1}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'hF, 1'b0}, 1'b0, 5'b00000},
        '{'{12'd0,    1'b1, 1'b0, 4'h3, 1'b1}, 1'b0, 5'b00000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gtac_in_if  tick_if ();
    gtac_out_if stat_if ();

    gas_temp_alarm_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (stat_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    t_cfg alarm_cfg = '{RST_UNLOCK_CODE, RST_TEMP_LIMIT, RST_BLINK_GAS, RST_BLINK_TEMP,
                        RST_BLINK_BOTH, RST_MAX_ATTEMPTS};

    logic [DEF_SAMPLE_BITS-1:0] sample_hist [WINDOW_DEPTH] = '{default: '0};
    int                         hist_ptr    = 0;
    logic [18:0]                hist_sum    = '0;
    logic                       alarm_on    = 1'b0;
    logic                       gas_seen    = 1'b0;
    logic                       heat_seen   = 1'b0;
    logic [BLINK_W-1:0]         blink_ticks = '0;
    logic [2:0]                 led_state   = '0;
    logic [ATT_W-1:0]           bad_codes   = '0;

    t_result pending_status [$];
    t_known  known_q [$];

    logic    calm = 1'b0;
    int      mismatches = 0;
    int      status_beats = 0;
    int      over_beats = 0;
    int      blocked_beats = 0;
    int      alarm_beats = 0;
    int      quiet_cycles = 0;
    t_tick   accepted_tick;
    t_result predicted;
    t_known  known_entry;
    t_result got;
    t_result want;

    string status_field [4:0] = '{"alarm_led", "blocked_led", "wrong_code_led",
                                  "alarm_active", "over_temp"};

    function automatic t_result next_status(t_tick tk);
        t_result            res;
        logic               over;
        logic               have;
        logic [BLINK_W-1:0] half;
        hist_sum = hist_sum - 19'(sample_hist[hist_ptr]) + 19'(tk.temp_sample);
        sample_hist[hist_ptr] = tk.temp_sample;
        hist_ptr = (hist_ptr == WINDOW_DEPTH - 1) ? 0 : hist_ptr + 1;
        over = hist_sum > alarm_cfg.temp_limit_sum;

        if (!tk.gas_sense_n) begin
            gas_seen = 1'b1;
            alarm_on = 1'b1;
        end
        if (over) begin
            heat_seen = 1'b1;
            alarm_on  = 1'b1;
        end
        if (tk.test_button) begin
            gas_seen  = 1'b1;
            heat_seen = 1'b1;
            alarm_on  = 1'b1;
        end

        if (alarm_on) begin
            have = 1'b1;
            half = '0;
            if (blink_ticks != COUNT_MAX) blink_ticks = blink_ticks + 1'b1;
            if (gas_seen && heat_seen) half = alarm_cfg.blink_both_ticks;
            else if (gas_seen) half = alarm_cfg.blink_gas_ticks;
            else if (heat_seen) half = alarm_cfg.blink_temp_ticks;
            else have = 1'b0;
            if (have && blink_ticks >= half) begin
                blink_ticks = '0;
                led_state[LED_ALARM] = ~led_state[LED_ALARM];
            end
        end else begin
            led_state = '0;
            gas_seen  = 1'b0;
            heat_seen = 1'b0;
        end

        if (bad_codes < alarm_cfg.max_wrong_attempts) begin
            if (tk.code_keys == '1 && !tk.enter_button) led_state[LED_WRONG] = 1'b0;
            if (tk.enter_button && !led_state[LED_WRONG] && alarm_on) begin
                if (tk.code_keys == alarm_cfg.unlock_code) begin
                    alarm_on  = 1'b0;
                    bad_codes = '0;
                end else begin
                    led_state[LED_WRONG] = 1'b1;
                    bad_codes = bad_codes + 1'b1;
                end
            end
        end else begin
            led_state[LED_BLOCKED] = 1'b1;
        end

        res.alarm_led      = led_state[LED_ALARM];
        res.blocked_led    = led_state[LED_BLOCKED];
        res.wrong_code_led = led_state[LED_WRONG];
        res.alarm_active   = alarm_on;
        res.over_temp      = over;
        return res;
    endfunction

    task automatic push_tick(t_tick tk, logic known, t_result status);
        if (!calm) begin
            while ($urandom_range(99) < 6) begin
                tick_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        tick_if.valid        <= 1'b1;
        tick_if.temp_sample  <= tk.temp_sample;
        tick_if.gas_sense_n  <= tk.gas_sense_n;
        tick_if.test_button  <= tk.test_button;
        tick_if.code_keys    <= tk.code_keys;
        tick_if.enter_button <= tk.enter_button;
        known_q.push_back('{known, status});
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_UNLOCK_CODE:  alarm_cfg.unlock_code        = value[CODE_W-1:0];
            REG_TEMP_LIMIT:   alarm_cfg.temp_limit_sum     = value[LIMIT_W-1:0];
            REG_BLINK_GAS:    alarm_cfg.blink_gas_ticks    = value[BLINK_W-1:0];
            REG_BLINK_TEMP:   alarm_cfg.blink_temp_ticks   = value[BLINK_W-1:0];
            REG_BLINK_BOTH:   alarm_cfg.blink_both_ticks   = value[BLINK_W-1:0];
            REG_MAX_ATTEMPTS: alarm_cfg.max_wrong_attempts = value[ATT_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        stat_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            stat_if.ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            accepted_tick = '{tick_if.temp_sample, tick_if.gas_sense_n, tick_if.test_button,
                              tick_if.code_keys, tick_if.enter_button};
            predicted   = next_status(accepted_tick);
            known_entry = known_q.pop_front();
            pending_status.push_back(known_entry.known ? known_entry.status : predicted);
        end
        if (i_rst_n && stat_if.valid && stat_if.ready) begin
            got = '{stat_if.alarm_led, stat_if.blocked_led, stat_if.wrong_code_led,
                    stat_if.alarm_active, stat_if.over_temp};
            if (pending_status.size() == 0) begin
                $display("%0t: status beat with none expected, got %b", $time, got);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                for (int b = 4; b >= 0; b--) begin
                    if (got[b] !== want[b]) begin
                        $display("%0t: %s expected %0b, got %0b",
                                 $time, status_field[b], want[b], got[b]);
                        mismatches++;
                    end
                end
                status_beats++;
                over_beats    += got.over_temp;
                blocked_beats += got.blocked_led;
                alarm_beats   += got.alarm_active;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (stat_if.valid && stat_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int    level;
        int    temp_code;
        int    limit;
        int    pick;
        logic  wrong_ok;
        t_cfg  setting;
        t_tick tk;

        i_rst_n              = 1'b0;
        tick_if.valid        = 1'b0;
        tick_if.temp_sample  = '0;
        tick_if.gas_sense_n  = 1'b1;
        tick_if.test_button  = 1'b0;
        tick_if.code_keys    = '0;
        tick_if.enter_button = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            push_tick(DIRECTED[r].tick, DIRECTED[r].known, DIRECTED[r].status);
        tick_if.valid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            while (pending_status.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);

            level = $urandom_range(4095);
            if (phase == 1) begin
                setting = '{4'd0, 20'd0, 10'd1, 10'd1, 10'd1, 4'd1};
            end else if (phase == PHASES - 1) begin
                setting = '{4'hF, 20'hFFFFF, 10'd1023, 10'd1023, 10'd1023, 4'd15};
            end else begin
                limit = level * 100 + int'($urandom_range(6000)) - 3000;
                if (limit < 0) limit = 0;
                setting.unlock_code        = CODE_W'($urandom_range(15));
                setting.temp_limit_sum     = LIMIT_W'(limit);
                setting.blink_gas_ticks    = BLINK_W'($urandom_range(40, 1));
                setting.blink_temp_ticks   = BLINK_W'($urandom_range(40, 1));
                setting.blink_both_ticks   = BLINK_W'($urandom_range(40, 1));
                setting.max_wrong_attempts = (phase == 0) ? 4'd15 : ATT_W'($urandom_range(15, 1));
            end
            write_reg(REG_UNLOCK_CODE,  APB_DATA_W'({$urandom(), setting.unlock_code}));
            write_reg(REG_TEMP_LIMIT,   APB_DATA_W'({$urandom(), setting.temp_limit_sum}));
            write_reg(REG_BLINK_GAS,    APB_DATA_W'({$urandom(), setting.blink_gas_ticks}));
            write_reg(REG_BLINK_TEMP,   APB_DATA_W'({$urandom(), setting.blink_temp_ticks}));
            write_reg(REG_BLINK_BOTH,   APB_DATA_W'({$urandom(), setting.blink_both_ticks}));
            write_reg(REG_MAX_ATTEMPTS, APB_DATA_W'({$urandom(), setting.max_wrong_attempts}));
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            calm = (phase == 4);

            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 5) begin
                    temp_code = $urandom_range(4095);
                end else begin
                    temp_code = level + int'($urandom_range(600)) - 300;
                    if (temp_code < 0) temp_code = 0;
                    if (temp_code > 4095) temp_code = 4095;
                end
                tk.temp_sample = DEF_SAMPLE_BITS'(temp_code);
                tk.gas_sense_n = $urandom_range(99) >= 3;
                tk.test_button = $urandom_range(99) < 2;

                // Wrong codes are held back near the top count so the keypad never
                // locks for good when the attempt limit is at its maximum.
                wrong_ok = bad_codes < 13;
                pick = $urandom_range(99);
                tk.code_keys    = '0;
                tk.enter_button = 1'b0;
                if (pick < 45) begin
                    tk.code_keys = '0;
                end else if (pick < 55) begin
                    tk.code_keys = DEF_KEY_COUNT'($urandom_range(14));
                end else if (pick < 67) begin
                    tk.code_keys = '1;
                end else if (pick < 82) begin
                    tk.code_keys    = alarm_cfg.unlock_code;
                    tk.enter_button = 1'b1;
                end else if (wrong_ok && pick < 92) begin
                    tk.code_keys    = alarm_cfg.unlock_code ^ DEF_KEY_COUNT'($urandom_range(15, 1));
                    tk.enter_button = 1'b1;
                end else if (wrong_ok) begin
                    tk.code_keys    = DEF_KEY_COUNT'($urandom_range(15));
                    tk.enter_button = $urandom_range(1);
                end
                push_tick(tk, 1'b0, '0);
            end
            tick_if.valid <= 1'b0;
        end

        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        mismatches += pending_status.size();

        $display("Checked %0d status beats from directed ticks and %0d register settings.",
                 status_beats, PHASES);
        $display("Over-temperature in %0d, alarm active in %0d, keypad blocked in %0d.",
                 over_beats, alarm_beats, blocked_beats);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
